// ----- sv/frx_pkg.sv -----
package frx_pkg;

    // element and intermediate widths
    localparam int VAL_W = 32;
    localparam int MAG_W = 33;
    localparam int SUM_W = 66;
    localparam int LEN_W = 33;

    // plane codes and the row that holds w
    localparam logic [2:0] PLANE_LEFT = 3'd0;
    localparam logic [2:0] PLANE_FAR  = 3'd5;
    localparam logic [1:0] W_ROW      = 2'd3;

    typedef logic [MAG_W-1:0] mag_t;

    typedef struct packed {
        logic [3:0]              element_index;
        logic signed [VAL_W-1:0] element_value;
        logic                    load_done;
    } elem_t;

    typedef struct packed {
        logic [2:0]              plane_id;
        logic signed [VAL_W-1:0] coef_a;
        logic signed [VAL_W-1:0] coef_b;
        logic signed [VAL_W-1:0] coef_c;
        logic signed [VAL_W-1:0] coef_d;
        logic                    degenerate;
        logic                    last_plane;
    } plane_t;

endpackage

// ----- sv/frx_sqacc.sv -----
module frx_sqacc (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  frx_pkg::mag_t [2:0]         mags,
    output logic                        done,
    output logic [frx_pkg::SUM_W-1:0]   sum
);
    import frx_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [1:0]       idx_reg;
    logic [SUM_W-1:0] mcand_reg;
    logic [SUM_W-1:0] acc_reg;
    mag_t             mplr_reg;
    logic [1:0]       idx_inc;

    assign idx_inc = idx_reg + 2'd1;

    // control: one operand after another, each until its multiplier runs out of ones
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= 2'd0;
            end
            else if (busy_reg && mplr_reg == '0)
            begin
                if (idx_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    idx_reg <= idx_inc;
                end
            end
        end
    end

    // shift-add squaring, one multiplier bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg   <= '0;
            mplr_reg  <= mags[0];
            mcand_reg <= SUM_W'(mags[0]);
        end
        else if (busy_reg)
        begin
            if (mplr_reg == '0)
            begin
                if (idx_reg != 2'd2)
                begin
                    mplr_reg  <= mags[idx_inc];
                    mcand_reg <= SUM_W'(mags[idx_inc]);
                end
            end
            else
            begin
                if (mplr_reg[0])
                    acc_reg <= acc_reg + mcand_reg;
                mplr_reg  <= mplr_reg >> 1;
                mcand_reg <= mcand_reg << 1;
            end
        end
    end

    assign done = done_reg;
    assign sum  = acc_reg;

endmodule

// ----- sv/frx_isqrt.sv -----
module frx_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [frx_pkg::SUM_W-1:0]   radicand,
    output logic                        done,
    output logic [frx_pkg::LEN_W-1:0]   root
);
    import frx_pkg::*;

    localparam int STEPS = SUM_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] s_reg;
    logic [LEN_W+2:0] rem_reg;
    logic [LEN_W-1:0] root_reg;
    logic [LEN_W+2:0] rem_sh;
    logic [LEN_W+2:0] trial;
    logic             ge;

    // one root bit per cycle from the top pair of radicand bits
    assign rem_sh = {rem_reg[LEN_W:0], s_reg[SUM_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            s_reg    <= s_reg << 2;
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[LEN_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- sv/frx_div.sv -----
module frx_div #(
    parameter int NUM_W = 50
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [NUM_W-1:0]            num,
    input  logic [frx_pkg::LEN_W-1:0]   den,
    output logic                        done,
    output logic [NUM_W-1:0]            quo
);
    import frx_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [LEN_W-1:0] den_reg;
    logic [LEN_W-1:0] rem_reg;
    logic [LEN_W:0]   rem_sh;
    logic [LEN_W:0]   diff;
    logic             ge;

    // restoring division, one quotient bit per cycle
    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= ge ? diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- sv/frustum_plane_extractor.sv -----
// Channel   Dir  Type            Transaction
// elem      in   frx_pkg::elem_t one clip-matrix element, column-major index
// plane     out  frx_pkg::plane_t one normalized plane, left..far, last on far
//
// An element without load_done is only stored. An element with load_done starts a run
// of six planes; each one passes the fetch steps, the serial squarer and, unless its
// squared sum is zero, the square-root unit and the divider.
// Reset clears control only; the matrix memory holds whatever was written last.
// elem_stall stays high for the whole run; a plane held by plane_stall blocks the next one.
module frustum_plane_extractor #(
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            elem_valid,
    output logic            elem_stall,
    input  frx_pkg::elem_t  elem,
    output logic            plane_valid,
    input  logic            plane_stall,
    output frx_pkg::plane_t plane
);
    import frx_pkg::*;

    localparam int NUM_W = MAG_W + FRAC_BITS + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_FETCH, S_RAW, S_SQ, S_SQW, S_ISQ, S_ISQW, S_DIV, S_DIVW, S_EMIT
    } state_t;

    state_t                    state_reg;
    logic [2:0]                plane_reg;
    logic [1:0]                k_reg;
    logic                      out_valid_reg;
    plane_t                    out_reg;
    logic [VAL_W-1:0]          store_mem [16];
    logic [VAL_W-1:0]          rd_w_reg;
    logic [VAL_W-1:0]          rd_e_reg;
    logic [3:0][MAG_W-1:0]     raw_reg;
    logic [3:0][VAL_W-1:0]     coef_reg;
    logic                      degen_reg;
    logic [MAG_W-1:0]          raw_calc;
    mag_t [3:0]                mags;
    logic                      sq_done;
    logic [SUM_W-1:0]          sq_sum;
    logic                      rt_done;
    logic [LEN_W-1:0]          len;
    logic                      dv_done;
    logic [NUM_W-1:0]          dv_num;
    logic [NUM_W-1:0]          dv_quo;
    logic                      sat_neg;
    logic [VAL_W-1:0]          sat_val;
    logic                      accept;

    assign accept     = elem_valid && !elem_stall;
    assign elem_stall = (state_reg != S_IDLE);

    // matrix memory, two registered reads
    always_ff @(posedge clk)
    begin
        if (accept)
            store_mem[elem.element_index] <= elem.element_value;
        rd_w_reg <= store_mem[{k_reg, W_ROW}];
        rd_e_reg <= store_mem[{k_reg, plane_reg[2:1]}];
    end

    // w row plus or minus the selected row
    assign raw_calc = plane_reg[0]
        ? ({rd_w_reg[VAL_W-1], rd_w_reg} - {rd_e_reg[VAL_W-1], rd_e_reg})
        : ({rd_w_reg[VAL_W-1], rd_w_reg} + {rd_e_reg[VAL_W-1], rd_e_reg});

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            mags[i] = raw_reg[i][MAG_W-1] ? (~raw_reg[i] + 1'b1) : raw_reg[i];
    end

    // rounded numerator: |raw| scaled, plus half the length
    assign dv_num = (NUM_W'(mags[k_reg]) << FRAC_BITS) + NUM_W'(len >> 1);

    // saturate the quotient into 32 signed bits
    assign sat_neg = raw_reg[k_reg][MAG_W-1];
    always_comb
    begin
        if (sat_neg)
        begin
            if ((dv_quo[NUM_W-1:VAL_W] != '0) || (dv_quo[VAL_W-1] && dv_quo[VAL_W-2:0] != '0))
                sat_val = {1'b1, {(VAL_W-1){1'b0}}};
            else
                sat_val = ~dv_quo[VAL_W-1:0] + 1'b1;
        end
        else
        begin
            if (dv_quo[NUM_W-1:VAL_W-1] != '0)
                sat_val = {1'b0, {(VAL_W-1){1'b1}}};
            else
                sat_val = dv_quo[VAL_W-1:0];
        end
    end

    frx_sqacc u_sqacc (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_SQ),
        .mags     (mags[2:0]),
        .done     (sq_done),
        .sum      (sq_sum)
    );

    frx_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_ISQ),
        .radicand (sq_sum),
        .done     (rt_done),
        .root     (len)
    );

    frx_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DIV),
        .num      (dv_num),
        .den      (len),
        .done     (dv_done),
        .quo      (dv_quo)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            plane_reg     <= PLANE_LEFT;
            k_reg         <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // output slot drains when taken; S_EMIT refills it itself
            if (!plane_stall && state_reg != S_EMIT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && elem.load_done)
                    begin
                        plane_reg <= PLANE_LEFT;
                        k_reg     <= 2'd0;
                        state_reg <= S_FETCH;
                    end
                end
                S_FETCH: state_reg <= S_RAW;
                S_RAW:
                begin
                    k_reg <= k_reg + 2'd1;
                    state_reg <= (k_reg == 2'd3) ? S_SQ : S_FETCH;
                end
                S_SQ: state_reg <= S_SQW;
                S_SQW:
                begin
                    if (sq_done)
                        state_reg <= (sq_sum == '0) ? S_EMIT : S_ISQ;
                end
                S_ISQ: state_reg <= S_ISQW;
                S_ISQW:
                begin
                    if (rt_done)
                    begin
                        k_reg     <= 2'd0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: state_reg <= S_DIVW;
                S_DIVW:
                begin
                    if (dv_done)
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= (k_reg == 2'd3) ? S_EMIT : S_DIV;
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || !plane_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        k_reg         <= 2'd0;
                        if (plane_reg == PLANE_FAR)
                        begin
                            plane_reg <= PLANE_LEFT;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            plane_reg <= plane_reg + 3'd1;
                            state_reg <= S_FETCH;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RAW)
            raw_reg[k_reg] <= raw_calc;
        if (state_reg == S_SQW && sq_done)
            degen_reg <= (sq_sum == '0);
        if (state_reg == S_DIVW && dv_done)
            coef_reg[k_reg] <= sat_val;
        if (state_reg == S_EMIT && (!out_valid_reg || !plane_stall))
        begin
            out_reg.plane_id   <= plane_reg;
            out_reg.coef_a     <= degen_reg ? '0 : coef_reg[0];
            out_reg.coef_b     <= degen_reg ? '0 : coef_reg[1];
            out_reg.coef_c     <= degen_reg ? '0 : coef_reg[2];
            out_reg.coef_d     <= degen_reg ? '0 : coef_reg[3];
            out_reg.degenerate <= degen_reg;
            out_reg.last_plane <= (plane_reg == PLANE_FAR);
        end
    end

    assign plane_valid = out_valid_reg;
    assign plane       = out_reg;

    // a degenerate plane carries zero coefficients
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        plane_valid && plane.degenerate |->
            plane.coef_a == '0 && plane.coef_b == '0 && plane.coef_c == '0 && plane.coef_d == '0)
        else $error("degenerate plane with nonzero coefficients");

    // only the far plane closes a run
    a_last_far: assert property (@(posedge clk) disable iff (!rst_n)
        plane_valid && plane.last_plane |-> plane.plane_id == PLANE_FAR)
        else $error("last_plane on a plane other than far");

    // the final element starts a run that blocks further elements
    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && elem.load_done |=> elem_stall)
        else $error("final element did not start plane extraction");

endmodule
